// ===== sv/imu_serial_frame_receiver_macros.svh =====
// Assertion helpers for the checker of this block.
`ifndef IMU_SERIAL_FRAME_RECEIVER_MACROS_SVH
`define IMU_SERIAL_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/imu_sfr_pkg.sv =====
package imu_sfr_pkg;

	// frame bytes 3..14 are kept for decoding
	localparam int PAY_FIRST = 3;
	localparam int PAY_DEPTH = 12;

	// event queue between parser and decoder
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [7:0] MISS_LIMIT_RESET = 8'd128;

	// register indexes (paddr[2])
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		KIND_GOOD = 2'd0,
		KIND_BAD  = 2'd1,
		KIND_POLL = 2'd2
	} kind_t;

	typedef logic [PAY_DEPTH-1:0][7:0] pay_t;

	typedef struct packed {
		logic       protocol_mode;
		logic [7:0] miss_limit;
	} cfg_t;

	// one parser event: finished frame or poll tick
	typedef struct packed {
		kind_t kind;
		pay_t  payload;
	} evt_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [31:0] yaw_rate_raw;
		logic [31:0] accel_raw;
		logic [31:0] yaw_angle_raw;
		logic        disconnected;
		logic [7:0]  miss_count;
	} res_t;

endpackage

// ===== sv/imu_sfr_front.sv =====
module imu_sfr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  imu_sfr_pkg::cfg_t   cfg,
	input  logic                parser_clr,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tuser,
	input  logic                q_full,
	output logic                evt_push,
	output imu_sfr_pkg::evt_t   evt
);

	typedef enum logic [1:0] {
		PH_HUNT  = 2'b01,
		PH_FRAME = 2'b10
	} phase_t;

	// CRC-16/Modbus, one byte, bit steps unrolled
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	localparam logic [15:0] CRC_SEED   = 16'hFFFF;
	localparam logic [15:0] CRC_HEADER = crc16_byte(crc16_byte(CRC_SEED, 8'h01), 8'h03);

	phase_t              phase_q, phase_n;
	logic [8:0]          pos_q, pos_n, pos_v;
	logic [8:0]          len_q, len_n, len_v;
	logic [15:0]         crc_q, crc_n;
	logic [7:0]          sum_q, sum_n;
	logic [7:0]          prev_q, prev_n;
	imu_sfr_pkg::pay_t   pay_q, pay_n, pay_st;
	logic                fire;
	logic                finish;
	logic                good;
	logic                is_poll;

	assign s_tready = !q_full;
	assign fire     = s_tvalid && s_tready;

	// byte parser
	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		len_n   = len_q;
		crc_n   = crc_q;
		sum_n   = sum_q;
		prev_n  = prev_q;
		pay_st  = pay_q;
		pos_v   = pos_q + 9'd1;
		len_v   = len_q;
		finish  = 1'b0;
		good    = 1'b0;
		is_poll = 1'b0;
		if (fire) begin
			if (s_tuser) begin
				is_poll = 1'b1;
			end else begin
				// keep frame bytes 3..14
				if (phase_q == PH_FRAME) begin
					for (int i = 0; i < imu_sfr_pkg::PAY_DEPTH; i++) begin
						if (pos_q == 9'(i + imu_sfr_pkg::PAY_FIRST))
							pay_st[i] = s_tdata;
					end
				end
				if (cfg.protocol_mode) begin
					prev_n = s_tdata;
					if (phase_q != PH_FRAME) begin
						if (prev_q == 8'h01 && s_tdata == 8'h03) begin
							phase_n = PH_FRAME;
							crc_n   = CRC_HEADER;
							pos_n   = 9'd2;
						end
					end else begin
						len_v = (pos_q == 9'd2) ? ({1'b0, s_tdata} + 9'd5) : len_q;
						len_n = len_v;
						if (({1'b0, pos_q} + 10'd2) < {1'b0, len_v})
							crc_n = crc16_byte(crc_q, s_tdata);
						if (({1'b0, pos_q} + 10'd1) == {1'b0, len_v}) begin
							finish = 1'b1;
							good   = ({s_tdata, prev_q} == crc_q);
						end else begin
							pos_n = pos_v;
						end
					end
				end else begin
					if (phase_q != PH_FRAME) begin
						if (s_tdata == 8'h68)
							phase_n = PH_FRAME;
					end else begin
						len_v = (pos_v == 9'd1) ? {1'b0, s_tdata} : len_q;
						len_n = len_v;
						pos_n = pos_v;
						if (pos_v == 9'd1 && s_tdata == 8'h00) begin
							finish = 1'b1;
						end else if (pos_v == len_v) begin
							finish = 1'b1;
							good   = (sum_q == s_tdata);
						end else begin
							sum_n = sum_q + s_tdata;
						end
					end
				end
			end
		end
		pay_n = pay_st;
		// frame done or mode write: back to hunting
		if (finish || parser_clr) begin
			phase_n = PH_HUNT;
			pos_n   = '0;
			len_n   = '0;
			crc_n   = CRC_SEED;
			sum_n   = '0;
			pay_n   = '0;
		end
	end

	// event to the queue
	always_comb begin
		evt_push    = is_poll || finish;
		evt.payload = pay_st;
		if (is_poll)
			evt.kind = imu_sfr_pkg::KIND_POLL;
		else if (good)
			evt.kind = imu_sfr_pkg::KIND_GOOD;
		else
			evt.kind = imu_sfr_pkg::KIND_BAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			len_q   <= '0;
			crc_q   <= CRC_SEED;
			sum_q   <= '0;
			prev_q  <= '0;
			pay_q   <= '0;
		end else begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			len_q   <= len_n;
			crc_q   <= crc_n;
			sum_q   <= sum_n;
			prev_q  <= prev_n;
			pay_q   <= pay_n;
		end
	end

endmodule

// ===== sv/imu_sfr_queue.sv =====
module imu_sfr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  imu_sfr_pkg::evt_t   push_data,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output imu_sfr_pkg::evt_t   head
);

	imu_sfr_pkg::evt_t                 mem_q [imu_sfr_pkg::QUEUE_DEPTH];
	logic [imu_sfr_pkg::QPTR_W-1:0]    wr_q, rd_q;
	logic [imu_sfr_pkg::QCNT_W-1:0]    cnt_q;

	assign full  = (cnt_q == imu_sfr_pkg::QCNT_W'(imu_sfr_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== sv/imu_sfr_back.sv =====
module imu_sfr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  imu_sfr_pkg::cfg_t   cfg,
	input  logic                q_empty,
	input  imu_sfr_pkg::evt_t   q_head,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output imu_sfr_pkg::res_t   res
);

	localparam logic [31:0] OFS_RATE  = 32'd150000;
	localparam logic [31:0] OFS_ACCEL = 32'd20000;
	localparam logic [31:0] OFS_ANGLE = 32'd18000;

	function automatic logic [7:0] bcd_byte(input logic [7:0] x);
		return 8'(x[7:4]) * 8'd10 + 8'(x[3:0]);
	endfunction

	// sign-magnitude BCD triple
	function automatic logic [31:0] bcd_val(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		logic [17:0] mag;
		mag = 18'(bcd_byte(b0 & 8'h0F)) * 18'd10000 + 18'(bcd_byte(b1)) * 18'd100
			+ 18'(bcd_byte(b2));
		return b0[4] ? (32'd0 - 32'(mag)) : 32'(mag);
	endfunction

	imu_sfr_pkg::pay_t   p;
	imu_sfr_pkg::res_t   res_q, res_n;
	logic                valid_q;
	logic                good_q, good_n;
	logic [7:0]          miss_q, miss_n;
	logic [7:0]          limit;
	logic [8:0]          miss_inc;

	assign p        = q_head.payload;
	assign limit    = (cfg.miss_limit == 8'd0) ? 8'd1 : cfg.miss_limit;
	assign miss_inc = {1'b0, miss_q} + 9'd1;
	assign q_pop    = !q_empty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign res      = res_q;

	// decode and poll bookkeeping
	always_comb begin
		good_n = good_q;
		miss_n = miss_q;
		res_n  = res_q;
		if (q_pop) begin
			res_n.result_kind   = q_head.kind;
			res_n.yaw_rate_raw  = '0;
			res_n.accel_raw     = '0;
			res_n.yaw_angle_raw = '0;
			unique case (q_head.kind)
				imu_sfr_pkg::KIND_GOOD: begin
					good_n = 1'b1;
					if (cfg.protocol_mode) begin
						res_n.yaw_rate_raw  = {p[3], p[2], p[1], p[0]} - OFS_RATE;
						res_n.accel_raw     = {p[7], p[6], p[5], p[4]} - OFS_ACCEL;
						res_n.yaw_angle_raw = {p[11], p[10], p[9], p[8]} - OFS_ANGLE;
					end else begin
						res_n.yaw_rate_raw  = bcd_val(p[0], p[1], p[2]);
						res_n.accel_raw     = bcd_val(p[3], p[4], p[5]);
						res_n.yaw_angle_raw = bcd_val(p[6], p[7], p[8]);
					end
				end
				imu_sfr_pkg::KIND_POLL: begin
					good_n = 1'b0;
					if (good_q)
						miss_n = '0;
					else if (miss_inc > {1'b0, limit})
						miss_n = limit;
					else
						miss_n = miss_inc[7:0];
				end
				default: begin
				end
			endcase
			res_n.miss_count   = miss_n;
			res_n.disconnected = (miss_n >= limit);
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			good_q  <= 1'b0;
			miss_q  <= '0;
		end else begin
			if (q_pop)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
			good_q <= good_n;
			miss_q <= miss_n;
		end
	end

endmodule

// ===== sv/imu_serial_frame_receiver.sv =====
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    s_tdata: rx_byte; s_tuser: cmd
// m_*      out  m_tvalid/m_tready    m_tdata: rates and status; m_tuser: result_kind
// apb      in   psel/penable/pready  0x0 protocol_mode, 0x4 miss_limit
//
// One request per cycle while the event queue has room: the parser takes a byte
// or poll tick each cycle, and the CRC step is unrolled.
// A two-entry event queue parts the parser from the decoder and output register.
// s_tready drops only while the event queue is full; a stalled m_tready fills it.
// Async reset clears parser, poll counter and registers (mode 0, limit 128).
module imu_serial_frame_receiver (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] rx_byte
	input  logic          s_tuser,   // [0] cmd
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [111:0]  m_tdata,   // [31:0] yaw_rate_raw, [63:32] accel_raw,
	                                 // [95:64] yaw_angle_raw, [96] disconnected,
	                                 // [104:97] miss_count, rest zero
	output logic [1:0]    m_tuser,   // [1:0] result_kind
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	imu_sfr_pkg::cfg_t   cfg_q;
	imu_sfr_pkg::evt_t   evt, q_head;
	imu_sfr_pkg::res_t   res;
	logic                wr_en;
	logic                parser_clr;
	logic                evt_push;
	logic                q_full, q_empty, q_pop;

	// register port
	assign pready     = 1'b1;
	assign wr_en      = psel && penable && pwrite && pready;
	assign parser_clr = wr_en && (paddr[2] == imu_sfr_pkg::REG_MODE);
	assign prdata     = (paddr[2] == imu_sfr_pkg::REG_MODE) ? {31'd0, cfg_q.protocol_mode}
		: {24'd0, cfg_q.miss_limit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.protocol_mode <= 1'b0;
			cfg_q.miss_limit    <= imu_sfr_pkg::MISS_LIMIT_RESET;
		end else if (wr_en) begin
			if (paddr[2] == imu_sfr_pkg::REG_MODE)
				cfg_q.protocol_mode <= pwdata[0];
			else
				cfg_q.miss_limit <= pwdata[7:0];
		end
	end

	imu_sfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.parser_clr (parser_clr),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_full     (q_full),
		.evt_push   (evt_push),
		.evt        (evt)
	);

	imu_sfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (evt_push),
		.push_data (evt),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	imu_sfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	// result packing
	assign m_tuser = res.result_kind;
	assign m_tdata = {7'd0, res.miss_count, res.disconnected, res.yaw_angle_raw,
		res.accel_raw, res.yaw_rate_raw};

endmodule

// ===== sv/imu_sfr_checker.sv =====
`include "imu_serial_frame_receiver_macros.svh"

module imu_sfr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [111:0]  m_tdata,
	input logic [1:0]    m_tuser
);

	logic stall_hold;
	logic non_good;
	logic disc_shown;

	assign stall_hold = m_tvalid && !m_tready;
	assign non_good   = m_tvalid && (m_tuser != imu_sfr_pkg::KIND_GOOD);
	assign disc_shown = m_tvalid && m_tdata[96];

	// stalled result stays offered and unchanged
	`SFR_ASSERT_NEXT(a_hold_valid, stall_hold, m_tvalid, "result dropped while stalled")
	`SFR_ASSERT_NEXT(a_hold_data, stall_hold, $stable(m_tdata), "result changed while stalled")

	// bad frames and poll status carry no measurements
	`SFR_ASSERT_NOW(a_zero_meas, non_good, m_tdata[95:0] == 96'd0, "bad or poll result with data")

	// disconnect needs at least one miss since the limit is never below one
	`SFR_ASSERT_NOW(a_disc_count, disc_shown, m_tdata[104:97] != 8'd0, "disconnect at zero misses")

endmodule

bind imu_serial_frame_receiver imu_sfr_checker u_sfr_checker (.*);

// ===== bench/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one receiver request: a serial octet or a poll tick
	typedef struct packed {
		logic       tick;
		logic [7:0] octet;
	} rx_evt_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata  = 8'h00;   // [7:0] rx_byte
	logic         s_tuser  = 1'b0;    // [0] cmd
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;            // [31:0] yaw_rate_raw, [63:32] accel_raw,
	                                  // [95:64] yaw_angle_raw, [96] disconnected,
	                                  // [104:97] miss_count
	logic [1:0]   m_tuser;            // [1:0] result_kind
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [2:0]   paddr    = 3'd0;
	logic [31:0]  pwdata   = 32'd0;
	logic [31:0]  prdata;
	logic         pready;

	imu_serial_frame_receiver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// requests waiting to be sent, reports waiting to be seen
	rx_evt_t             rx_queue[$];
	imu_sfr_pkg::res_t   report_q[$];
	rx_evt_t             rx_next;
	logic                rx_taken   = 1'b0;
	int                  send_idle  = 0;
	int                  recv_idle  = 0;
	int                  stall_left = 0;
	int                  tick_mix   = 0;
	int                  pushed     = 0;
	int                  mismatches = 0;
	int                  n_good     = 0;
	int                  n_bad      = 0;
	int                  n_poll     = 0;

	// receiver state as the block should hold it
	logic        mode_q;
	logic [7:0]  limit_q;
	logic        in_frame;
	int          fpos;
	int          flen;
	logic [15:0] crc_acc;
	logic [7:0]  sum_acc;
	logic [15:0] last_two;
	logic [7:0]  pay [imu_sfr_pkg::PAY_DEPTH];
	logic        seen_good;
	logic [7:0]  misses;

	function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] d);
		int k;
		c = c ^ {8'h00, d};
		for (k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	function automatic logic [31:0] bcd_pair(logic [7:0] x);
		return 32'(x[7:4]) * 10 + 32'(x[3:0]);
	endfunction

	// sign-magnitude BCD triple starting at payload index k
	function automatic logic [31:0] bcd_field(int k);
		logic [31:0] mag;
		mag = bcd_pair({4'h0, pay[k][3:0]}) * 10000 + bcd_pair(pay[k+1]) * 100
			+ bcd_pair(pay[k+2]);
		return pay[k][4] ? -mag : mag;
	endfunction

	function automatic logic [31:0] le_word(int k);
		return {pay[k+3], pay[k+2], pay[k+1], pay[k]};
	endfunction

	function automatic logic [7:0] limit_eff();
		return (limit_q == 8'd0) ? 8'd1 : limit_q;
	endfunction

	function automatic imu_sfr_pkg::res_t status_report(imu_sfr_pkg::kind_t kind,
			logic [31:0] a, logic [31:0] b, logic [31:0] c);
		imu_sfr_pkg::res_t r;
		r.result_kind   = kind;
		r.yaw_rate_raw  = a;
		r.accel_raw     = b;
		r.yaw_angle_raw = c;
		r.disconnected  = (misses >= limit_eff());
		r.miss_count    = misses;
		return r;
	endfunction

	function automatic void parser_reset();
		in_frame = 1'b0;
		fpos     = 0;
		flen     = 0;
		crc_acc  = 16'hFFFF;
		sum_acc  = 8'h00;
		foreach (pay[i])
			pay[i] = 8'h00;
	endfunction

	function automatic imu_sfr_pkg::res_t close_frame(logic good);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		imu_sfr_pkg::res_t r;
		a = '0;
		b = '0;
		c = '0;
		if (good) begin
			if (mode_q) begin
				a = le_word(0) - 32'd150000;
				b = le_word(4) - 32'd20000;
				c = le_word(8) - 32'd18000;
			end else begin
				a = bcd_field(0);
				b = bcd_field(3);
				c = bcd_field(6);
			end
			seen_good = 1'b1;
			r = status_report(imu_sfr_pkg::KIND_GOOD, a, b, c);
		end else begin
			r = status_report(imu_sfr_pkg::KIND_BAD, a, b, c);
		end
		parser_reset();
		return r;
	endfunction

	function automatic void keep_octet(logic [7:0] d);
		if (fpos >= imu_sfr_pkg::PAY_FIRST
				&& fpos < imu_sfr_pkg::PAY_FIRST + imu_sfr_pkg::PAY_DEPTH)
			pay[fpos - imu_sfr_pkg::PAY_FIRST] = d;
	endfunction

	// advance the receiver by one request; returns 1 when a report is due
	function automatic logic receiver_step(rx_evt_t ev, output imu_sfr_pkg::res_t r);
		logic [7:0] prv;
		r = '0;
		if (ev.tick) begin
			if (seen_good)
				misses = 8'd0;
			else if (int'(misses) + 1 > int'(limit_eff()))
				misses = limit_eff();
			else
				misses = misses + 8'd1;
			seen_good = 1'b0;
			r = status_report(imu_sfr_pkg::KIND_POLL, '0, '0, '0);
			return 1'b1;
		end
		if (mode_q) begin
			// Modbus: last two octets shift on every byte, even inside a frame
			prv = last_two[7:0];
			last_two = {prv, ev.octet};
			if (!in_frame) begin
				if (prv == 8'h01 && ev.octet == 8'h03) begin
					in_frame = 1'b1;
					crc_acc  = crc16_step(crc16_step(16'hFFFF, 8'h01), 8'h03);
					fpos     = 2;
				end
				return 1'b0;
			end
			if (fpos == 2)
				flen = int'(ev.octet) + 5;
			keep_octet(ev.octet);
			if (fpos + 2 < flen)
				crc_acc = crc16_step(crc_acc, ev.octet);
			if (fpos + 1 == flen) begin
				r = close_frame({ev.octet, prv} == crc_acc);
				return 1'b1;
			end
			fpos++;
			return 1'b0;
		end
		// header mode: 0x68, length, body, additive checksum
		if (!in_frame) begin
			if (ev.octet == 8'h68) begin
				parser_reset();
				in_frame = 1'b1;
			end
			return 1'b0;
		end
		keep_octet(ev.octet);
		fpos++;
		if (fpos == 1) begin
			flen = int'(ev.octet);
			if (ev.octet == 8'h00) begin
				r = close_frame(1'b0);
				return 1'b1;
			end
		end
		if (fpos == flen) begin
			r = close_frame(sum_acc == ev.octet);
			return 1'b1;
		end
		sum_acc = sum_acc + ev.octet;
		return 1'b0;
	endfunction

	// stimulus builders
	function automatic void put(logic tick, logic [7:0] d);
		rx_queue.push_back(rx_evt_t'{tick: tick, octet: d});
		pushed++;
	endfunction

	// frame octet, with an occasional poll tick slipped in ahead of it
	function automatic void put_framed(logic [7:0] d);
		if ($urandom_range(99) < tick_mix)
			put(1'b1, 8'($urandom));
		put(1'b0, d);
	endfunction

	function automatic logic [7:0] bcd_octet(int j);
		if ($urandom_range(4) == 0)
			return 8'($urandom);
		if (j % 3 == 0)
			return {3'b000, 1'($urandom), 4'($urandom_range(9))};
		return {4'($urandom_range(9)), 4'($urandom_range(9))};
	endfunction

	// fill < 0 gives random content, else every octet between length and checksum is fill
	function automatic void send_header(int len, bit corrupt, int fill);
		logic [7:0] body [$];
		logic [7:0] s;
		int j;
		body.push_back(8'(len));
		for (j = 1; j < len - 1; j++)
			body.push_back(fill >= 0 ? 8'(fill) : bcd_octet(j));
		if (len >= 2) begin
			s = 8'h00;
			foreach (body[k])
				s = s + body[k];
			body.push_back(s);
			if (corrupt)
				body[$urandom_range(body.size() - 1, 1)] ^= 8'(1 << $urandom_range(7));
		end
		put_framed(8'h68);
		foreach (body[k])
			put_framed(body[k]);
	endfunction

	// end01 tunes the last data octet so the CRC high octet is 0x01;
	// chain leaves out the leading 0x01, to pair with such a trailing one
	function automatic void send_modbus(int count, bit corrupt, bit end01, bit chain, int fill);
		logic [7:0] body [$];
		logic [15:0] c;
		logic [15:0] c0;
		int j;
		body = {8'h01, 8'h03, 8'(count)};
		for (j = 0; j < count; j++)
			body.push_back(fill >= 0 ? 8'(fill) : 8'($urandom));
		if (end01 && count > 0) begin
			c0 = 16'hFFFF;
			for (j = 0; j < body.size() - 1; j++)
				c0 = crc16_step(c0, body[j]);
			for (j = 0; j < 256; j++) begin
				c = crc16_step(c0, 8'(j));
				if (c[15:8] == 8'h01) begin
					body[body.size() - 1] = 8'(j);
					break;
				end
			end
		end
		c = 16'hFFFF;
		foreach (body[k])
			c = crc16_step(c, body[k]);
		body.push_back(c[7:0]);
		body.push_back(c[15:8]);
		if (corrupt)
			body[$urandom_range(body.size() - 1, 3)] ^= 8'(1 << $urandom_range(7));
		for (j = chain ? 1 : 0; j < body.size(); j++)
			put_framed(body[j]);
	endfunction

	// mostly well-formed frames in the current mode, mixed with polls and line noise
	function automatic void random_mix(int n_items);
		int start;
		int pick;
		int sz;
		bit bad;
		start = pushed;
		while (pushed - start < n_items) begin
			pick = $urandom_range(99);
			bad = ($urandom_range(99) < 12);
			sz = $urandom_range(99);
			if (pick < 70) begin
				if (mode_q) begin
					if (sz < 5) begin
						send_modbus(12, 1'b0, 1'b1, 1'b0, -1);
						send_modbus(12, bad, 1'b0, 1'b1, -1);
					end else begin
						send_modbus(sz < 75 ? 12 : (sz < 97 ? $urandom_range(16) :
							$urandom_range(255, 17)), bad, 1'b0, 1'b0, -1);
					end
				end else begin
					send_header(sz < 75 ? 12 : (sz < 97 ? $urandom_range(20) :
						$urandom_range(255, 21)), bad, -1);
				end
			end else if (pick < 82) begin
				put(1'b1, 8'($urandom));
			end else begin
				repeat ($urandom_range(3, 1))
					put(1'b0, 8'($urandom));
			end
		end
	endfunction

	// wait for every request to go and every report to arrive, then let it settle
	task automatic wait_idle();
		while (rx_queue.size() != 0 || s_tvalid || report_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == imu_sfr_pkg::REG_MODE) begin
			mode_q = val[0];
			parser_reset();
		end else begin
			limit_q = val[7:0];
		end
	endtask

	task automatic run_phase(logic m, logic [7:0] lim, int sidle, int ridle, int n, int stall);
		wait_idle();
		write_reg(imu_sfr_pkg::REG_LIMIT, 32'(lim));
		write_reg(imu_sfr_pkg::REG_MODE, 32'(m));
		send_idle = sidle;
		recv_idle = ridle;
		random_mix(n);
		@(posedge clk);
		stall_left = stall;
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || rx_taken)) begin
			if (rx_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
				rx_next = rx_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= rx_next.octet;
				s_tuser  <= rx_next.tick;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// report sink: random back-pressure, or a counted hold-off
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor: predict on accepted requests, check accepted reports
	always @(posedge clk) begin
		imu_sfr_pkg::res_t want;
		imu_sfr_pkg::res_t got;
		rx_taken = arst_n && s_tvalid && (s_tready === 1'b1);
		if (rx_taken) begin
			if (receiver_step(rx_evt_t'{tick: s_tuser, octet: s_tdata}, want))
				report_q.push_back(want);
		end
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got.result_kind   = imu_sfr_pkg::kind_t'(m_tuser);
			got.yaw_rate_raw  = m_tdata[31:0];
			got.accel_raw     = m_tdata[63:32];
			got.yaw_angle_raw = m_tdata[95:64];
			got.disconnected  = m_tdata[96];
			got.miss_count    = m_tdata[104:97];
			if (report_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: report with none expected, kind %0d", $realtime,
						m_tuser);
			end else begin
				want = report_q.pop_front();
				case (want.result_kind)
					imu_sfr_pkg::KIND_GOOD: n_good++;
					imu_sfr_pkg::KIND_BAD:  n_bad++;
					default:                n_poll++;
				endcase
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%t: report mismatch (exp/got) kind %0d/%0d",
							" yaw_rate %0d/%0d accel %0d/%0d yaw_angle %0d/%0d",
							" disc %0b/%0b misses %0d/%0d"}, $realtime,
							want.result_kind, got.result_kind,
							$signed(want.yaw_rate_raw), $signed(got.yaw_rate_raw),
							$signed(want.accel_raw), $signed(got.accel_raw),
							$signed(want.yaw_angle_raw), $signed(got.yaw_angle_raw),
							want.disconnected, got.disconnected,
							want.miss_count, got.miss_count);
				end
			end
		end
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		mode_q    = 1'b0;
		limit_q   = imu_sfr_pkg::MISS_LIMIT_RESET;
		last_two  = 16'h0000;
		seen_good = 1'b0;
		misses    = 8'd0;
		parser_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle = 35;
		recv_idle = 35;

		// header mode out of reset: extremes, non-decimal digits, short,
		// zero-length, one-octet and bad-sum frames
		put(1'b1, 8'hFF);
		send_header(12, 1'b0, 8'h99);
		send_header(12, 1'b0, 8'hFF);
		send_header(12, 1'b0, 8'h00);
		send_header(0, 1'b0, -1);
		send_header(5, 1'b0, -1);
		send_header(1, 1'b0, -1);
		send_header(12, 1'b1, -1);
		put(1'b1, 8'h00);
		put(1'b1, 8'h5A);
		wait_idle();

		// a limit of zero behaves as one
		write_reg(imu_sfr_pkg::REG_LIMIT, 32'd0);
		put(1'b1, 8'h00);
		put(1'b1, 8'h00);
		send_header(12, 1'b0, -1);
		put(1'b1, 8'h00);
		put(1'b1, 8'h00);
		wait_idle();
		write_reg(imu_sfr_pkg::REG_LIMIT, 32'd255);
		put(1'b1, 8'h00);
		wait_idle();

		// Modbus: offset extremes, empty and bad-CRC frames, and a trailing
		// 0x01 that pairs with the next 0x03
		write_reg(imu_sfr_pkg::REG_MODE, 32'd1);
		send_modbus(12, 1'b0, 1'b0, 1'b0, 8'h00);
		send_modbus(12, 1'b0, 1'b0, 1'b0, 8'hFF);
		send_modbus(0, 1'b0, 1'b0, 1'b0, -1);
		send_modbus(12, 1'b1, 1'b0, 1'b0, -1);
		send_modbus(12, 1'b0, 1'b1, 1'b0, -1);
		send_modbus(12, 1'b0, 1'b0, 1'b1, -1);
		put(1'b1, 8'h00);

		// random traffic over several settings, ticks mixed into frames;
		// one phase holds the sink off long enough to back up the input
		tick_mix = 3;
		run_phase(1'b1, 8'd255, 35, 35, 200, 0);
		run_phase(1'b0, 8'd3, 0, 0, 150, 0);
		run_phase(1'b1, 8'd1, 35, 35, 150, 300);
		run_phase(1'b0, 8'd128, 35, 35, 200, 0);
		run_phase(1'b1, 8'd2, 35, 35, 200, 0);
		run_phase(1'b0, 8'd255, 35, 35, 150, 0);
		run_phase(1'b1, 8'd5, 35, 35, 150, 0);
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Sent %0d requests, checked %0d good, %0d failed, %0d poll reports.",
			pushed, n_good, n_bad, n_poll);
		$display("Both framings, limits 0 to 255, ticks inside frames, output stalls.");
		if (mismatches == 0 && report_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
